// File: sv/phwp_pkg.sv
package phwp_pkg;

    localparam int BINS       = 256;
    localparam int COUNT_BITS = 24;
    localparam int IDX_BITS   = $clog2(BINS);

    localparam int IN_DATA_BITS  = 8;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_CNT_BITS  = 24;
    localparam int OUT_DATA_BITS = 2 * OUT_CNT_BITS;
    localparam int OUT_USER_BITS = 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [IN_USER_BITS-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } hist_cmd_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic push;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/phwp_ctrl.sv
module phwp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  phwp_pkg::dp_stat_t stat,
    output phwp_pkg::ctl_cmd_t cmd
);
    import phwp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_PUSH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                // hold the result until the output register frees up
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/phwp_dp.sv
module phwp_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [phwp_pkg::IN_DATA_BITS-1:0]      s_tdata,
    input  logic [phwp_pkg::IN_USER_BITS-1:0]      s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [phwp_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    output logic [phwp_pkg::OUT_USER_BITS-1:0]     m_tuser,
    input  phwp_pkg::ctl_cmd_t                     cmd,
    output phwp_pkg::dp_stat_t                     stat
);
    import phwp_pkg::*;

    logic [COUNT_BITS-1:0]   bins_mem [BINS];
    logic [BINS-1:0]         vld_reg;

    logic [IDX_BITS-1:0]     in_idx;
    logic [IN_USER_BITS-1:0] item_cmd_reg;
    logic [IN_DATA_BITS-1:0] item_val_reg;
    logic [COUNT_BITS-1:0]   rd_data_reg;
    logic                    rd_vld_reg;
    logic [COUNT_BITS-1:0]   peak_reg;
    logic [COUNT_BITS-1:0]   peak_next;

    logic [COUNT_BITS-1:0]   res_count_reg;
    logic [COUNT_BITS-1:0]   res_peak_reg;
    logic                    res_sat_reg;

    logic                    m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;
    logic [OUT_USER_BITS-1:0] m_tuser_reg;

    logic                    is_clear;
    logic                    is_add;
    logic                    in_range;
    logic [COUNT_BITS-1:0]   cur_count;
    logic                    inc_ok;
    logic [COUNT_BITS-1:0]   new_count;
    logic [IDX_BITS-1:0]     item_idx;

    assign in_idx   = IDX_BITS'(s_tdata);
    assign item_idx = IDX_BITS'(item_val_reg);
    assign is_clear = (item_cmd_reg == CMD_CLEAR);
    assign is_add   = (item_cmd_reg == CMD_ADD);
    assign in_range = (32'(item_val_reg) < BINS);

    // a bin whose valid bit is low was cleared and reads as zero
    assign cur_count = rd_vld_reg ? rd_data_reg : '0;
    assign inc_ok    = is_add && in_range && (cur_count != COUNT_MAX);
    assign new_count = inc_ok ? cur_count + 1'b1 : cur_count;

    always_comb
    begin
        peak_next = peak_reg;
        if (is_clear)
        begin
            peak_next = '0;
        end
        else if (inc_ok && (new_count > peak_reg))
        begin
            peak_next = new_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_cmd_reg <= s_tuser;
            item_val_reg <= s_tdata;
            rd_data_reg  <= bins_mem[in_idx];
            rd_vld_reg   <= vld_reg[in_idx];
        end
        if (cmd.update && inc_ok)
        begin
            bins_mem[item_idx] <= new_count;
        end
        if (cmd.update)
        begin
            res_count_reg <= (is_clear || !in_range) ? '0 : new_count;
            res_peak_reg  <= peak_next;
            res_sat_reg   <= !is_clear && in_range && (new_count == COUNT_MAX);
        end
        if (cmd.push)
        begin
            m_tdata_reg <= {OUT_CNT_BITS'(res_peak_reg), OUT_CNT_BITS'(res_count_reg)};
            m_tuser_reg <= res_sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            peak_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                peak_reg <= peak_next;
                if (is_clear)
                begin
                    vld_reg <= '0;
                end
                else if (inc_ok)
                begin
                    vld_reg[item_idx] <= 1'b1;
                end
            end
            if (cmd.push)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

endmodule

// File: sv/pixel_histogram_with_peak.sv
// Gray-level histogram with a running peak. Each input word carries a
// command in s_tuser (add pixel, read bin, clear all) and a gray level or
// bin index in s_tdata; each word returns exactly one result word with the
// addressed bin's count after the update, the peak count, and a saturation
// flag in m_tuser. Bins and peak are cleared at reset and by a clear
// command. One word is in flight at a time: the bin memory is read at the
// accepting edge, the update and write-back follow in the S_UPD state, and
// the result register loads in the S_PUSH state once it is free. A new word
// is taken only after the last has passed through S_PUSH; a stalled result
// word holds off the next acceptance. A clear takes effect at once through
// per-bin valid bits, with no sweep of the bin memory.
module pixel_histogram_with_peak (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [phwp_pkg::IN_DATA_BITS-1:0]   s_tdata,  // [7:0] value
    input  logic [phwp_pkg::IN_USER_BITS-1:0]   s_tuser,  // [1:0] cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [phwp_pkg::OUT_DATA_BITS-1:0]  m_tdata,  // [23:0] bin_count, [47:24] peak_count
    output logic [phwp_pkg::OUT_USER_BITS-1:0]  m_tuser   // [0] saturated
);
    import phwp_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    phwp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    phwp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (ctl_cmd),
        .stat     (dp_stat)
    );

endmodule

// File: sv/phwp_checker.sv
module phwp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [phwp_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input logic [phwp_pkg::IN_USER_BITS-1:0]   s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [phwp_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input logic [phwp_pkg::OUT_USER_BITS-1:0]  m_tuser
);
    import phwp_pkg::*;

    logic [OUT_CNT_BITS-1:0] out_count;
    logic [OUT_CNT_BITS-1:0] out_peak;

    assign out_count = m_tdata[OUT_CNT_BITS-1:0];
    assign out_peak  = m_tdata[OUT_DATA_BITS-1:OUT_CNT_BITS];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // no bin exceeds the peak since the last clear
    a_count_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_count <= out_peak)
        else $error("bin count above peak");

    // saturation flag only with a full count
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> out_count == OUT_CNT_BITS'(COUNT_MAX))
        else $error("saturated flag without a full count");

endmodule

bind pixel_histogram_with_peak phwp_checker u_phwp_checker (.*);

// File: sim/pixel_histogram_with_peak_checker.sv
module pixel_histogram_with_peak_checker
    import phwp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [7:0] value
    input  logic [IN_USER_BITS-1:0]  s_tuser,   // [1:0] cmd
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,   // [23:0] bin_count, [47:24] peak_count
    input  logic [OUT_USER_BITS-1:0] m_tuser,   // [0] saturated
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        logic [OUT_CNT_BITS-1:0] bin_count;
        logic [OUT_CNT_BITS-1:0] peak_count;
        logic                    saturated;
    } hist_word_t;

    logic [COUNT_BITS-1:0] bin_tally [BINS];
    logic [COUNT_BITS-1:0] peak_tally;
    hist_word_t            hist_expected_q [$];

    function automatic void clear_histogram();
        for (int i = 0; i < BINS; i++)
            bin_tally[i] = '0;
        peak_tally = '0;
    endfunction

    function automatic hist_word_t histogram_update(logic [IN_USER_BITS-1:0] cmd,
                                                    logic [IN_DATA_BITS-1:0] idx);
        hist_word_t            w;
        logic [COUNT_BITS-1:0] c;
        w = '0;
        if (cmd == CMD_CLEAR)
        begin
            clear_histogram();
        end
        else if (idx < BINS)
        begin
            // any other command, the spare one included, only reads the bin
            c = bin_tally[idx];
            if (cmd == CMD_ADD && c != COUNT_MAX)
            begin
                c = c + 1'b1;
                bin_tally[idx] = c;
                if (c > peak_tally)
                    peak_tally = c;
            end
            w.bin_count = c[OUT_CNT_BITS-1:0];
            w.saturated = (c == COUNT_MAX);
        end
        w.peak_count = peak_tally[OUT_CNT_BITS-1:0];
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hist_word_t exp_w;
        hist_word_t got_w;
        if (!rst_n)
        begin
            clear_histogram();
            hist_expected_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                hist_expected_q.push_back(histogram_update(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got_w.bin_count  = m_tdata[OUT_CNT_BITS-1:0];
                got_w.peak_count = m_tdata[2*OUT_CNT_BITS-1:OUT_CNT_BITS];
                got_w.saturated  = m_tuser[0];
                if (hist_expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with none expected: bin %0d peak %0d sat %0b",
                             $time, got_w.bin_count, got_w.peak_count, got_w.saturated);
                end
                else
                begin
                    exp_w = hist_expected_q.pop_front();
                    if (got_w.bin_count !== exp_w.bin_count)
                    begin
                        errors++;
                        $display("%0t: bin_count expected %0d actual %0d",
                                 $time, exp_w.bin_count, got_w.bin_count);
                    end
                    if (got_w.peak_count !== exp_w.peak_count)
                    begin
                        errors++;
                        $display("%0t: peak_count expected %0d actual %0d",
                                 $time, exp_w.peak_count, got_w.peak_count);
                    end
                    if (got_w.saturated !== exp_w.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, exp_w.saturated, got_w.saturated);
                    end
                end
            end
            pending = hist_expected_q.size();
        end
    end

endmodule

// File: sim/pixel_histogram_with_peak_tb.sv
module pixel_histogram_with_peak_tb;
    import phwp_pkg::*;

    localparam logic [IN_USER_BITS-1:0] CMD_SPARE = 2'd3;
    localparam int ITEMS_PER_PHASE = 267;
    localparam int STALL_LIMIT     = 4000;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [IN_USER_BITS-1:0]  s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;

    int   errors;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   stall_cycles  = 0;
    logic word_taken    = 1'b0;

    always #2 clk = ~clk;

    pixel_histogram_with_peak dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pixel_histogram_with_peak_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge clk)
        word_taken <= s_tvalid && s_tready;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [IN_USER_BITS-1:0] cmd,
                             input logic [IN_DATA_BITS-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do
            @(negedge clk);
        while (!word_taken);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_random_words(input int n);
        int                      r;
        logic [IN_DATA_BITS-1:0] hot_base;
        logic [IN_DATA_BITS-1:0] v;
        hot_base = IN_DATA_BITS'($urandom_range(255));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            // half the time hit one of four hot bins so counts and the peak keep climbing
            if ($urandom_range(1))
                v = hot_base + IN_DATA_BITS'($urandom_range(3));
            else
                v = IN_DATA_BITS'($urandom_range(255));
            if (r < 2)
            begin
                send_word(CMD_CLEAR, IN_DATA_BITS'($urandom_range(255)));
                hot_base = IN_DATA_BITS'($urandom_range(255));
            end
            else if (r < 6)
                send_word(CMD_SPARE, v);
            else if (r < 24)
                send_word(CMD_READ, v);
            else
                send_word(CMD_ADD, v);
        end
    endtask

    initial
    begin
        send_idle_pct = 7;
        recv_idle_pct = 55;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty bins, back-to-back adds on one bin, both ends of the range
        send_word(CMD_READ,  8'h00);
        send_word(CMD_READ,  8'hFF);
        send_word(CMD_ADD,   8'h00);
        send_word(CMD_ADD,   8'h00);
        send_word(CMD_ADD,   8'h00);
        send_word(CMD_ADD,   8'hFF);
        send_word(CMD_ADD,   8'hFF);
        send_word(CMD_READ,  8'h00);
        send_word(CMD_READ,  8'hFF);
        send_word(CMD_SPARE, 8'h00);
        send_word(CMD_ADD,   8'hAA);
        send_word(CMD_ADD,   8'h55);
        send_word(CMD_CLEAR, 8'hFF);
        send_word(CMD_READ,  8'h00);
        send_word(CMD_READ,  8'hFF);
        send_word(CMD_ADD,   8'hFF);
        send_word(CMD_ADD,   8'h80);
        send_word(CMD_ADD,   8'h01);
        send_word(CMD_ADD,   8'h80);
        send_word(CMD_READ,  8'h80);
        send_word(CMD_SPARE, 8'h7F);
        send_word(CMD_CLEAR, 8'h00);
        send_word(CMD_ADD,   8'h7F);

        send_random_words(ITEMS_PER_PHASE);
        drain_results();

        send_idle_pct = 55;
        recv_idle_pct = 7;
        send_random_words(ITEMS_PER_PHASE);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_words(ITEMS_PER_PHASE);
        drain_results();
        repeat (12) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
